/* hw/rtl/fbsr_pkg.sv */
// fbsr_pkg: shared types and constants for the frame buffer slot rotation unit.
// No dependencies; used by every file under hw/rtl.
package fbsr_pkg;

	localparam int ADDR_W   = 32;
	localparam int STRIDE_W = 28;
	localparam int RES_W    = 12;
	localparam int LEN_W    = 2 * RES_W + 1;
	localparam int SHOWN_W  = 2;

	localparam logic [ADDR_W-1:0]   BASE_RESET   = 32'h4480_0000;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 28'd4147200;
	localparam logic [RES_W-1:0]    H_RESET      = 12'd1920;
	localparam logic [RES_W-1:0]    V_RESET      = 12'd1080;

	typedef enum logic [1:0] {
		REG_FRAME_BASE   = 2'd0,
		REG_FRAME_STRIDE = 2'd1,
		REG_H_PIXELS     = 2'd2,
		REG_V_LINES      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   frame_base;
		logic [STRIDE_W-1:0] frame_stride;
		logic [LEN_W-1:0]    expected_len;
	} cfg_t;

	typedef struct packed {
		logic              slot0_pending;
		logic [ADDR_W-1:0] slot0_end_address;
		logic              slot1_pending;
		logic [ADDR_W-1:0] slot1_end_address;
	} item_t;

	typedef struct packed {
		logic               slot0_reload;
		logic [ADDR_W-1:0]  slot0_address;
		logic               slot1_reload;
		logic [ADDR_W-1:0]  slot1_address;
		logic               frame_ready;
		logic [SHOWN_W-1:0] shown_buffer;
		logic               slot0_length_bad;
		logic               slot1_length_bad;
		logic               slot0_stray;
		logic               slot1_stray;
	} res_t;

endpackage

/* hw/rtl/fbsr_cfg.sv */
// fbsr_cfg: configuration registers and the expected frame length.
// Depends on fbsr_pkg.
module fbsr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [1:0]                    cfg_index,
	input  logic [fbsr_pkg::ADDR_W-1:0]   cfg_data,
	output fbsr_pkg::cfg_t                cfg
);

	logic [fbsr_pkg::ADDR_W-1:0]   base_q;
	logic [fbsr_pkg::STRIDE_W-1:0] stride_q;
	logic [fbsr_pkg::RES_W-1:0]    h_q;
	logic [fbsr_pkg::RES_W-1:0]    v_q;
	logic [2*fbsr_pkg::RES_W-1:0]  area;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= fbsr_pkg::BASE_RESET;
			stride_q <= fbsr_pkg::STRIDE_RESET;
			h_q      <= fbsr_pkg::H_RESET;
			v_q      <= fbsr_pkg::V_RESET;
		end else if (cfg_write_en) begin
			case (fbsr_pkg::reg_idx_t'(cfg_index))
				fbsr_pkg::REG_FRAME_BASE:   base_q   <= cfg_data;
				fbsr_pkg::REG_FRAME_STRIDE: stride_q <= cfg_data[fbsr_pkg::STRIDE_W-1:0];
				fbsr_pkg::REG_H_PIXELS:     h_q      <= cfg_data[fbsr_pkg::RES_W-1:0];
				fbsr_pkg::REG_V_LINES:      v_q      <= cfg_data[fbsr_pkg::RES_W-1:0];
				default: ;
			endcase
		end
	end

	// two bytes per pixel
	assign area             = h_q * v_q;
	assign cfg.frame_base   = base_q;
	assign cfg.frame_stride = stride_q;
	assign cfg.expected_len = {area, 1'b0};

endmodule

/* hw/rtl/fbsr_core.sv */
// fbsr_core: slot buffer state and per-request rotation logic.
// Depends on fbsr_pkg; configuration comes from fbsr_cfg.
module fbsr_core #(
	parameter int BUFFER_COUNT = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  fbsr_pkg::item_t item,
	input  fbsr_pkg::cfg_t  cfg,
	output fbsr_pkg::res_t  res
);

	localparam int IW = $clog2(BUFFER_COUNT);
	localparam int PW = fbsr_pkg::STRIDE_W + IW;
	localparam int SW = fbsr_pkg::STRIDE_W + $clog2(BUFFER_COUNT + 1) + 1;
	localparam int AW = fbsr_pkg::ADDR_W;

	logic [IW-1:0] slot0_buf_q, slot1_buf_q, next_buf_q, shown_q;
	logic [IW-1:0] slot0_buf_n, slot1_buf_n, next_buf_n, shown_n;
	logic [IW-1:0] next_adv, next_adv2, next_mid;
	logic [AW-1:0] start0, start1, start_n, start_n2;
	logic [AW-1:0] len0, len1, expected;
	logic [SW-1:0] stray_lo, stray_hi;
	logic          match0, match1, take0, take1, stray0, stray1;
	logic          pend0, pend1;

	function automatic logic [AW-1:0] buf_start(input logic [IW-1:0] idx,
			input logic [AW-1:0] base, input logic [fbsr_pkg::STRIDE_W-1:0] stride);
		logic [PW-1:0] prod;
		prod = PW'(idx) * PW'(stride);
		return base + AW'(prod);
	endfunction

	function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx);
		logic [IW:0] n;
		n = {1'b0, idx} + 1'b1;
		return (n >= (IW+1)'(BUFFER_COUNT)) ? '0 : n[IW-1:0];
	endfunction

	assign pend0 = item.slot0_pending;
	assign pend1 = item.slot1_pending;

	assign start0   = buf_start(slot0_buf_q, cfg.frame_base, cfg.frame_stride);
	assign start1   = buf_start(slot1_buf_q, cfg.frame_base, cfg.frame_stride);
	assign start_n  = buf_start(next_buf_q, cfg.frame_base, cfg.frame_stride);
	assign next_adv = advance(next_buf_q);
	assign next_adv2 = advance(next_adv);
	assign start_n2 = buf_start(next_adv, cfg.frame_base, cfg.frame_stride);

	// length against the 28-bit masked buffer start, wraps at 32 bits
	assign expected = AW'(cfg.expected_len);
	assign len0   = item.slot0_end_address - {4'b0, start0[fbsr_pkg::STRIDE_W-1:0]};
	assign len1   = item.slot1_end_address - {4'b0, start1[fbsr_pkg::STRIDE_W-1:0]};
	assign match0 = (len0 == expected);
	assign match1 = (len1 == expected);
	assign take0  = pend0 && match0;
	assign take1  = pend1 && match1;

	assign stray_lo = SW'(cfg.frame_base[fbsr_pkg::STRIDE_W-1:0]);
	assign stray_hi = stray_lo + SW'(cfg.frame_stride) * SW'(BUFFER_COUNT);
	assign stray0 = (SW'(item.slot0_end_address) < stray_lo) ||
			(SW'(item.slot0_end_address) > stray_hi);
	assign stray1 = (SW'(item.slot1_end_address) < stray_lo) ||
			(SW'(item.slot1_end_address) > stray_hi);

	// slot 0 first, slot 1 sees the ring counter that slot 0 left
	assign slot0_buf_n = take0 ? next_buf_q : slot0_buf_q;
	assign next_mid    = take0 ? next_adv : next_buf_q;
	assign slot1_buf_n = take1 ? next_mid : slot1_buf_q;
	assign next_buf_n  = take1 ? (take0 ? next_adv2 : next_adv) : next_mid;
	assign shown_n     = take1 ? slot1_buf_q : (take0 ? slot0_buf_q : shown_q);

	always_comb begin
		res = '0;
		res.slot0_reload     = pend0;
		res.slot0_address    = pend0 ? (take0 ? start_n : start0) : '0;
		res.slot0_length_bad = pend0 && !match0;
		res.slot0_stray      = pend0 && stray0;
		res.slot1_reload     = pend1;
		res.slot1_address    = pend1 ? (take1 ? (take0 ? start_n2 : start_n) : start1) : '0;
		res.slot1_length_bad = pend1 && !match1;
		res.slot1_stray      = pend1 && stray1;
		res.frame_ready      = take0 || take1;
		res.shown_buffer     = shown_n[fbsr_pkg::SHOWN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot0_buf_q <= IW'(0);
			slot1_buf_q <= IW'(1);
			next_buf_q  <= IW'(2);
			shown_q     <= IW'(3);
		end else if (step) begin
			slot0_buf_q <= slot0_buf_n;
			slot1_buf_q <= slot1_buf_n;
			next_buf_q  <= next_buf_n;
			shown_q     <= shown_n;
		end
	end

	a_ring_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(IW+1)'(next_buf_q) < (IW+1)'(BUFFER_COUNT)
		&& (IW+1)'(slot0_buf_q) < (IW+1)'(BUFFER_COUNT)
		&& (IW+1)'(slot1_buf_q) < (IW+1)'(BUFFER_COUNT))
		else $error("buffer index out of ring");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(shown_q) && $stable(next_buf_q)
			&& $stable(slot0_buf_q) && $stable(slot1_buf_q))
		else $error("slot state changed without a request");

	a_ring_moves_with_frames: assert property (@(posedge clk) disable iff (!arst_n)
		step && !res.frame_ready |=> $stable(next_buf_q))
		else $error("ring counter moved without an accepted frame");

	a_idle_slot_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!pend0 |-> res.slot0_address == '0 && !res.slot0_length_bad && !res.slot0_stray)
		else $error("idle slot 0 reports activity");

endmodule

/* hw/rtl/frame_buffer_slot_rotation_unit.sv */
// frame_buffer_slot_rotation_unit: top level, input register, result register.
// Depends on fbsr_pkg, fbsr_cfg and fbsr_core.
//
//  channel | handshake                    | payload
//  --------+------------------------------+------------------------------------------
//  in      | in_valid / in_stall          | slot0/1 pending, end address
//  out     | out_valid / out_stall        | reload, address, frame_ready, shown, flags
//  cfg     | cfg_write_en                 | cfg_index, cfg_data
//
// A request waits in the input register and then leaves through the result register;
// one request per cycle is sustained while out is not stalled.
// Slot state is updated as the request moves from the input into the result register.
// Reset restores the register defaults and buffer indexes 0, 1, 2 and 3.
// A stall on out holds the result register; in stalls only while both registers are full.
module frame_buffer_slot_rotation_unit #(
	parameter int BUFFER_COUNT = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [1:0]                  cfg_index,
	input  logic [fbsr_pkg::ADDR_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        slot0_pending,
	input  logic [fbsr_pkg::ADDR_W-1:0] slot0_end_address,
	input  logic                        slot1_pending,
	input  logic [fbsr_pkg::ADDR_W-1:0] slot1_end_address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        slot0_reload,
	output logic [fbsr_pkg::ADDR_W-1:0] slot0_address,
	output logic                        slot1_reload,
	output logic [fbsr_pkg::ADDR_W-1:0] slot1_address,
	output logic                        frame_ready,
	output logic [fbsr_pkg::SHOWN_W-1:0] shown_buffer,
	output logic                        slot0_length_bad,
	output logic                        slot1_length_bad,
	output logic                        slot0_stray,
	output logic                        slot1_stray
);

	fbsr_pkg::cfg_t  cfg;
	fbsr_pkg::item_t item_s1;
	fbsr_pkg::res_t  res, res_q;
	logic            valid_s1, out_valid_q;
	logic            out_load, in_load;

	assign out_load = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_load;
	assign in_load  = in_valid && !in_stall;

	fbsr_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	fbsr_core #(
		.BUFFER_COUNT (BUFFER_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && out_load),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_load || out_load)
				valid_s1 <= in_load;
			if (out_load)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_load) begin
			item_s1.slot0_pending     <= slot0_pending;
			item_s1.slot0_end_address <= slot0_end_address;
			item_s1.slot1_pending     <= slot1_pending;
			item_s1.slot1_end_address <= slot1_end_address;
		end
		if (out_load && valid_s1)
			res_q <= res;
	end

	assign out_valid        = out_valid_q;
	assign slot0_reload     = res_q.slot0_reload;
	assign slot0_address    = res_q.slot0_address;
	assign slot1_reload     = res_q.slot1_reload;
	assign slot1_address    = res_q.slot1_address;
	assign frame_ready      = res_q.frame_ready;
	assign shown_buffer     = res_q.shown_buffer;
	assign slot0_length_bad = res_q.slot0_length_bad;
	assign slot1_length_bad = res_q.slot1_length_bad;
	assign slot0_stray      = res_q.slot0_stray;
	assign slot1_stray      = res_q.slot1_stray;

endmodule
